>>> hdl/sed_pkg.sv
package sed_pkg;

  // Escape mode codes
  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeEsc     = 3'd1;
  localparam logic [2:0] ModeHex     = 3'd2;
  localparam logic [2:0] ModeDec     = 3'd3;
  localparam logic [2:0] ModeZ       = 3'd4;
  localparam logic [2:0] ModeUBrace  = 3'd5;
  localparam logic [2:0] ModeUDigits = 3'd6;

  // Result slots produced by one input byte
  localparam int unsigned MaxResults = 4;
  localparam int unsigned SlotW      = $clog2(MaxResults);
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // Characters with special meaning
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChCloseBr   = 8'h7D;

  // Decoded results of one request, handed to the output buffer
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       marker;
    logic                       last;
    logic                       cut;
  } res_t;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch[3:0];
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      v = ch[3:0] + 4'd9;
    end else begin
      // low nibble of ch - 'A' + 10
      v = ch[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == 8'h20 || ch == 8'h09 || ch == 8'h0A || ch == 8'h0D ||
           ch == 8'h0C || ch == 8'h0B;
  endfunction

endpackage

>>> hdl/sed_decode.sv
module sed_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output sed_pkg::res_t res_o
);
  import sed_pkg::*;

  logic [2:0]  mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;

  logic [MaxResults-1:0][7:0] bytes;
  logic [CountW-1:0]          n;
  logic [9:0]                 dec_val;
  logic [1:0]                 cnt_inc;
  logic                       cut;
  logic                       marker;

  always_comb begin
    dec_val = (acc_q[9:0] << 3) + (acc_q[9:0] << 1) + {6'd0, byte_i[3:0]};
    cnt_inc = cnt_q + 2'd1;
  end

  // Decode one byte against the current escape mode
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    bytes  = '0;
    n      = '0;
    cut    = 1'b0;
    marker = 1'b0;
    unique case (mode_q)
      ModeEsc: begin
        mode_d = ModeIdle;
        case (byte_i)
          8'h61: begin bytes[0] = 8'd7;  n = CountW'(1); end
          8'h62: begin bytes[0] = 8'd8;  n = CountW'(1); end
          8'h66: begin bytes[0] = 8'd12; n = CountW'(1); end
          8'h6E: begin bytes[0] = 8'd10; n = CountW'(1); end
          8'h72: begin bytes[0] = 8'd13; n = CountW'(1); end
          8'h74: begin bytes[0] = 8'd9;  n = CountW'(1); end
          8'h76: begin bytes[0] = 8'd11; n = CountW'(1); end
          ChBackslash, ChDquote, ChSquote, ChNewline: begin
            bytes[0] = byte_i;
            n = CountW'(1);
          end
          8'h78: begin mode_d = ModeHex; cnt_d = '0; acc_d = '0; end
          8'h7A: mode_d = ModeZ;
          8'h75: mode_d = ModeUBrace;
          default: begin
            if (is_digit(byte_i)) begin
              mode_d = ModeDec;
              acc_d  = {28'd0, byte_i[3:0]};
              cnt_d  = 2'd1;
            end else begin
              bytes[0] = ChBackslash;
              bytes[1] = byte_i;
              n = CountW'(2);
            end
          end
        endcase
      end
      ModeHex: begin
        if (cnt_q == 2'd0) begin
          acc_d = {28'd0, hex_value(byte_i)};
          cnt_d = 2'd1;
        end else begin
          bytes[0] = {acc_q[3:0], hex_value(byte_i)};
          n = CountW'(1);
          mode_d = ModeIdle;
          acc_d  = '0;
          cnt_d  = '0;
        end
      end
      ModeDec: begin
        if (is_digit(byte_i)) begin
          acc_d = {22'd0, dec_val};
          cnt_d = cnt_inc;
          if (cnt_inc == 2'd3) begin
            bytes[0] = dec_val[7:0];
            n = CountW'(1);
            mode_d = ModeIdle;
            acc_d  = '0;
            cnt_d  = '0;
          end
        end else begin
          // flush pending value, then handle the byte as in idle mode
          bytes[0] = acc_q[7:0];
          mode_d = ModeIdle;
          acc_d  = '0;
          cnt_d  = '0;
          if (byte_i == ChBackslash) begin
            mode_d = ModeEsc;
            n = CountW'(1);
          end else begin
            bytes[1] = byte_i;
            n = CountW'(2);
          end
        end
      end
      ModeZ: begin
        if (!is_space(byte_i)) begin
          mode_d = ModeIdle;
          if (byte_i == ChBackslash) begin
            mode_d = ModeEsc;
          end else begin
            bytes[0] = byte_i;
            n = CountW'(1);
          end
        end
      end
      ModeUBrace: begin
        mode_d = ModeUDigits;
        acc_d  = '0;
      end
      ModeUDigits: begin
        if (byte_i == ChCloseBr) begin
          mode_d = ModeIdle;
          acc_d  = '0;
          if (acc_q <= 32'h7F) begin
            bytes[0] = acc_q[7:0];
            n = CountW'(1);
          end else if (acc_q <= 32'h7FF) begin
            bytes[0] = 8'hC0 | acc_q[13:6];
            bytes[1] = 8'h80 | {2'b00, acc_q[5:0]};
            n = CountW'(2);
          end else if (acc_q <= 32'hFFFF) begin
            bytes[0] = 8'hE0 | acc_q[19:12];
            bytes[1] = 8'h80 | {2'b00, acc_q[11:6]};
            bytes[2] = 8'h80 | {2'b00, acc_q[5:0]};
            n = CountW'(3);
          end else begin
            bytes[0] = 8'hF0 | acc_q[25:18];
            bytes[1] = 8'h80 | {2'b00, acc_q[17:12]};
            bytes[2] = 8'h80 | {2'b00, acc_q[11:6]};
            bytes[3] = 8'h80 | {2'b00, acc_q[5:0]};
            n = CountW'(4);
          end
        end else begin
          acc_d = {acc_q[27:0], hex_value(byte_i)};
        end
      end
      default: begin
        mode_d = ModeIdle;
        if (byte_i == ChBackslash) begin
          mode_d = ModeEsc;
        end else begin
          bytes[0] = byte_i;
          n = CountW'(1);
        end
      end
    endcase

    // End of string: flush decimal, flag unfinished escapes, mark empty results, restart
    if (last_i) begin
      if (mode_d == ModeDec) begin
        bytes[0] = acc_d[7:0];
        n = CountW'(1);
      end
      cut = mode_d == ModeEsc || mode_d == ModeHex ||
            mode_d == ModeUBrace || mode_d == ModeUDigits;
      if (n == '0) begin
        marker = 1'b1;
        n = CountW'(1);
      end
      mode_d = ModeIdle;
      acc_d  = '0;
      cnt_d  = '0;
    end
  end

  assign res_o = '{bytes: bytes, count: n, marker: marker, last: last_i, cut: cut};

  // Advance escape state on each decoded request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hdl/sed_out_buf.sv
module sed_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sed_pkg::res_t res_i,
  output logic          can_load_o,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          out_last_o,
  output logic          cut_short_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);
  import sed_pkg::*;

  logic [MaxResults-1:0][7:0] bytes_q;
  logic [CountW-1:0]          rem_q;
  logic [SlotW-1:0]           idx_q;
  logic                       marker_q;
  logic                       last_q;
  logic                       cut_q;
  logic                       take;
  logic                       final_slot;

  assign out_valid_o = rem_q != '0;
  assign take        = out_valid_o && out_ready_i;
  assign final_slot  = rem_q == CountW'(1);
  assign can_load_o  = !out_valid_o || (final_slot && out_ready_i);

  assign out_byte_o   = bytes_q[idx_q];
  assign byte_valid_o = !marker_q;
  assign out_last_o   = last_q && final_slot;
  assign cut_short_o  = cut_q && final_slot;

  // Hold the result bytes of one request
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= res_i.bytes;
      marker_q <= res_i.marker;
      last_q   <= res_i.last;
      cut_q    <= res_i.cut;
    end
  end

  // Advance through the slots, one per taken result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      rem_q <= res_i.count;
      idx_q <= '0;
    end else if (take) begin
      rem_q <= rem_q - CountW'(1);
      idx_q <= idx_q + SlotW'(1);
    end
  end

endmodule

>>> hdl/string_escape_decoder_unit.sv
// A request enters the input register when accepted; its results, if any, move
// into the result buffer once it can load. Throughput: one byte per cycle while
// out_ready_i is high and each byte yields at most one result; a byte yielding
// more (up to four) stalls the input until all but its last result are taken.
// Reset (rst_ni low, asynchronous) clears the escape state and empties both
// the input register and the result buffer.
module string_escape_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       out_last_o,
  output logic       cut_short_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);
  import sed_pkg::*;

  logic       full_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       can_load;
  logic       move;
  logic       in_take;
  res_t       res;

  assign move       = full_q && can_load;
  assign in_ready_o = !full_q || move;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register: capture one request
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_take) begin
      full_q <= 1'b1;
    end else if (move) begin
      full_q <= 1'b0;
    end
  end

  sed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (move),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  sed_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (move && res.count != '0),
    .res_i        (res),
    .can_load_o   (can_load),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o),
    .cut_short_o  (cut_short_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

>>> hdl/sed_checker.sv
module sed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       out_last_o,
  input logic       cut_short_o,
  input logic       out_valid_o,
  input logic       out_ready_i
);

  // Cut-short flag appears only on the final result of a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cut_short_o |-> out_last_o)
    else $error("cut_short without out_last");

  // An empty marker is only ever the end of a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_last_o)
    else $error("empty marker not at end of string");

  // With nothing waiting at the output the input must be open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled result changed");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_byte_o   (out_byte_o),
  .byte_valid_o (byte_valid_o),
  .out_last_o   (out_last_o),
  .cut_short_o  (cut_short_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i)
);
